// File: hw/rtl/cor_pkg.sv
// ============================================================================
// cor_pkg
// Shared types and constants for the circle overlap resolver datapath.
// ============================================================================
package cor_pkg;

    localparam int COORD_W   = 24;  // centre coordinate width
    localparam int RAD_W     = 8;   // radius width, whole pixels
    localparam int RSUM_W    = 9;   // sum of two radii
    localparam int ELAS_W    = 9;   // elasticity register width
    localparam int ELAS_FRAC = 8;   // elasticity is in units of 1/256
    localparam int DIFF_W    = 25;  // centre difference and its magnitude
    localparam int SQ_W      = 50;  // squared distance
    localparam int ROOT_W    = 25;  // integer square root of SQ_W bits

    localparam logic [ELAS_W-1:0] ELAS_RESET = 9'd128;
    localparam logic [ELAS_W-1:0] ELAS_MAX   = 9'd256;

    typedef struct packed {
        logic signed [COORD_W-1:0] first_x_in;
        logic signed [COORD_W-1:0] first_y_in;
        logic        [RAD_W-1:0]   first_radius;
        logic signed [COORD_W-1:0] second_x_in;
        logic signed [COORD_W-1:0] second_y_in;
        logic        [RAD_W-1:0]   second_radius;
    } t_pair_in;

    typedef struct packed {
        logic signed [COORD_W-1:0] first_x_out;
        logic signed [COORD_W-1:0] first_y_out;
        logic signed [COORD_W-1:0] second_x_out;
        logic signed [COORD_W-1:0] second_y_out;
        logic                      overlapped;
    } t_pair_out;

    // Sideband carried alongside the square root pipeline
    typedef struct packed {
        logic signed [COORD_W-1:0] x1;
        logic signed [COORD_W-1:0] y1;
        logic signed [COORD_W-1:0] x2;
        logic signed [COORD_W-1:0] y2;
        logic                      neg_x;
        logic                      neg_y;
        logic        [DIFF_W-1:0]  mag_x;
        logic        [DIFF_W-1:0]  mag_y;
        logic        [RSUM_W-1:0]  rsum;
    } t_sqrt_side;

    // Sideband carried alongside the divider pipeline
    typedef struct packed {
        logic signed [COORD_W-1:0] x1;
        logic signed [COORD_W-1:0] y1;
        logic signed [COORD_W-1:0] x2;
        logic signed [COORD_W-1:0] y2;
        logic                      neg_x;
        logic                      neg_y;
        logic                      hit;
    } t_div_side;

endpackage

// File: hw/rtl/cor_sqrt.sv
// ============================================================================
// cor_sqrt
// Pipelined floor integer square root, one result bit per register stage.
// ============================================================================
module cor_sqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [cor_pkg::SQ_W-1:0]    i_radicand,
    input  cor_pkg::t_sqrt_side         i_side,
    output logic                        o_valid,
    output logic [cor_pkg::ROOT_W-1:0]  o_root,
    output cor_pkg::t_sqrt_side         o_side
);
    import cor_pkg::*;

    logic              w_vld  [0:ROOT_W];
    logic [SQ_W-1:0]   w_rem  [0:ROOT_W];
    logic [SQ_W-1:0]   w_root [0:ROOT_W];
    t_sqrt_side        w_side [0:ROOT_W];

    assign w_vld[0]  = i_valid;
    assign w_rem[0]  = i_radicand;
    assign w_root[0] = '0;
    assign w_side[0] = i_side;

    for (genvar g = 0; g < ROOT_W; g++) begin : g_stage
        localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (ROOT_W - 1 - g));

        logic              r_vld;
        logic [SQ_W-1:0]   r_rem;
        logic [SQ_W-1:0]   r_root;
        t_sqrt_side        r_side;
        logic [SQ_W-1:0]   n_rem;
        logic [SQ_W-1:0]   n_root;
        logic [SQ_W-1:0]   trial;

        // Try the next root bit; keep it when the remainder allows
        always_comb begin
            trial = w_root[g] + BIT;
            if (w_rem[g] >= trial) begin
                n_rem  = w_rem[g] - trial;
                n_root = (w_root[g] >> 1) + BIT;
            end else begin
                n_rem  = w_rem[g];
                n_root = w_root[g] >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else begin
                r_vld <= w_vld[g];
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem  <= n_rem;
            r_root <= n_root;
            r_side <= w_side[g];
        end

        assign w_vld[g+1]  = r_vld;
        assign w_rem[g+1]  = r_rem;
        assign w_root[g+1] = r_root;
        assign w_side[g+1] = r_side;
    end

    assign o_valid = w_vld[ROOT_W];
    assign o_root  = w_root[ROOT_W][ROOT_W-1:0];
    assign o_side  = w_side[ROOT_W];

endmodule

// File: hw/rtl/cor_div.sv
// ============================================================================
// cor_div
// Pipelined restoring divider for two numerators over one shared divisor,
// one quotient bit per register stage, most significant bit first.
// ============================================================================
module cor_div #(
    parameter int NUM_W = 44,
    parameter int DEN_W = 25,
    parameter int QUO_W = 17
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [NUM_W-1:0]     i_num_x,
    input  logic [NUM_W-1:0]     i_num_y,
    input  logic [DEN_W-1:0]     i_den,
    input  cor_pkg::t_div_side   i_side,
    output logic                 o_valid,
    output logic [QUO_W-1:0]     o_quo_x,
    output logic [QUO_W-1:0]     o_quo_y,
    output cor_pkg::t_div_side   o_side
);
    import cor_pkg::*;

    logic               w_vld  [0:QUO_W];
    logic [NUM_W-1:0]   w_rx   [0:QUO_W];
    logic [NUM_W-1:0]   w_ry   [0:QUO_W];
    logic [QUO_W-1:0]   w_qx   [0:QUO_W];
    logic [QUO_W-1:0]   w_qy   [0:QUO_W];
    logic [DEN_W-1:0]   w_den  [0:QUO_W];
    t_div_side          w_side [0:QUO_W];

    assign w_vld[0]  = i_valid;
    assign w_rx[0]   = i_num_x;
    assign w_ry[0]   = i_num_y;
    assign w_qx[0]   = '0;
    assign w_qy[0]   = '0;
    assign w_den[0]  = i_den;
    assign w_side[0] = i_side;

    for (genvar g = 0; g < QUO_W; g++) begin : g_stage
        localparam int K = QUO_W - 1 - g;

        logic               r_vld;
        logic [NUM_W-1:0]   r_rx;
        logic [NUM_W-1:0]   r_ry;
        logic [QUO_W-1:0]   r_qx;
        logic [QUO_W-1:0]   r_qy;
        logic [DEN_W-1:0]   r_den;
        t_div_side          r_side;
        logic [NUM_W-1:0]   n_rx;
        logic [NUM_W-1:0]   n_ry;
        logic [QUO_W-1:0]   n_qx;
        logic [QUO_W-1:0]   n_qy;
        logic [NUM_W-1:0]   shifted;

        // Subtract the aligned divisor where it fits and shift in the bit
        always_comb begin
            shifted = NUM_W'(w_den[g]) << K;
            if (w_rx[g] >= shifted) begin
                n_rx = w_rx[g] - shifted;
                n_qx = {w_qx[g][QUO_W-2:0], 1'b1};
            end else begin
                n_rx = w_rx[g];
                n_qx = {w_qx[g][QUO_W-2:0], 1'b0};
            end
            if (w_ry[g] >= shifted) begin
                n_ry = w_ry[g] - shifted;
                n_qy = {w_qy[g][QUO_W-2:0], 1'b1};
            end else begin
                n_ry = w_ry[g];
                n_qy = {w_qy[g][QUO_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else begin
                r_vld <= w_vld[g];
            end
        end

        always_ff @(posedge i_clk) begin
            r_rx   <= n_rx;
            r_ry   <= n_ry;
            r_qx   <= n_qx;
            r_qy   <= n_qy;
            r_den  <= w_den[g];
            r_side <= w_side[g];
        end

        assign w_vld[g+1]  = r_vld;
        assign w_rx[g+1]   = r_rx;
        assign w_ry[g+1]   = r_ry;
        assign w_qx[g+1]   = r_qx;
        assign w_qy[g+1]   = r_qy;
        assign w_den[g+1]  = r_den;
        assign w_side[g+1] = r_side;
    end

    assign o_valid = w_vld[QUO_W];
    assign o_quo_x = w_qx[QUO_W];
    assign o_quo_y = w_qy[QUO_W];
    assign o_side  = w_side[QUO_W];

endmodule

// File: hw/rtl/circle_overlap_resolver.sv
// ============================================================================
// circle_overlap_resolver
// Position correction for one pair of overlapping circles per transfer.
// ============================================================================
// Usage:
//   Input channel: drive i_pair and raise start; the pair is taken at any
//   rising edge with start high and busy low. busy stays low, so one pair
//   may be issued in every cycle.
//   Output channel: o_valid is high for exactly one cycle with o_result;
//   the receiver must take it then, as there is no back-pressure.
//   Configuration: i_cfg_we writes i_cfg_wdata into the elasticity
//   register (units of 1/256, values above 256 act as 256). Write only
//   while no pair is in flight.
//   Throughput: one pair per cycle. The depth is set by the 25-stage square
//   root and the (9 + FRACTION_BITS)-stage divider, each resolving one bit
//   per stage.
//   Reset: synchronous, active low; empties the pipeline and sets the
//   elasticity to 128.
// ============================================================================
module circle_overlap_resolver #(
    parameter int FRACTION_BITS = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [cor_pkg::ELAS_W-1:0]    i_cfg_wdata,
    input  logic                          start,
    input  cor_pkg::t_pair_in             i_pair,
    output logic                          busy,
    output logic                          o_valid,
    output cor_pkg::t_pair_out            o_result
);
    import cor_pkg::*;

    localparam int SW     = RSUM_W + FRACTION_BITS;      // radius sum, fixed point
    localparam int PROD_W = ELAS_W + SW;                 // elasticity times depth
    localparam int MUL_W  = PROD_W + SW;                 // times axis magnitude
    localparam int NUM_W  = MUL_W + 1;                   // plus rounding half
    localparam int DEN_W  = SW + ELAS_FRAC;              // length times 256
    localparam int QUO_W  = SW;                          // offset magnitude
    localparam int EXT_W  = ((SW > COORD_W) ? SW : COORD_W) + 2;

    // Clamp an extended coordinate into the signed coordinate range
    function automatic logic [COORD_W-1:0] sat_coord(input logic [EXT_W-1:0] v);
        logic [COORD_W-1:0] res;
        if (v[EXT_W-1:COORD_W-1] == '0 || v[EXT_W-1:COORD_W-1] == '1) begin
            res = v[COORD_W-1:0];
        end else if (v[EXT_W-1]) begin
            res = {1'b1, {(COORD_W-1){1'b0}}};
        end else begin
            res = {1'b0, {(COORD_W-1){1'b1}}};
        end
        return res;
    endfunction

    // ---------------------------------------------------------------- config
    logic [ELAS_W-1:0] r_elas;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elas <= ELAS_RESET;
        end else if (i_cfg_we) begin
            r_elas <= i_cfg_wdata;
        end
    end

    assign busy = 1'b0;

    // ------------------------------------------------- stage A: input capture
    logic     r_a_vld;
    t_pair_in r_a_in;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else begin
            r_a_vld <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_in <= i_pair;
    end

    // ------------------------------------- stage B: differences and magnitudes
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    t_sqrt_side               n_b_side;
    logic                     r_b_vld;
    t_sqrt_side               r_b_side;

    always_comb begin
        dx = {r_a_in.first_x_in[COORD_W-1], r_a_in.first_x_in}
           - {r_a_in.second_x_in[COORD_W-1], r_a_in.second_x_in};
        dy = {r_a_in.first_y_in[COORD_W-1], r_a_in.first_y_in}
           - {r_a_in.second_y_in[COORD_W-1], r_a_in.second_y_in};
        n_b_side.x1    = r_a_in.first_x_in;
        n_b_side.y1    = r_a_in.first_y_in;
        n_b_side.x2    = r_a_in.second_x_in;
        n_b_side.y2    = r_a_in.second_y_in;
        n_b_side.neg_x = dx[DIFF_W-1];
        n_b_side.neg_y = dy[DIFF_W-1];
        n_b_side.mag_x = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
        n_b_side.mag_y = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
        n_b_side.rsum  = RSUM_W'(r_a_in.first_radius) + RSUM_W'(r_a_in.second_radius);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else begin
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_side <= n_b_side;
    end

    // ------------------------------------------------------ stage C: squares
    logic            r_c_vld;
    logic [SQ_W-1:0] r_c_sqx;
    logic [SQ_W-1:0] r_c_sqy;
    t_sqrt_side      r_c_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else begin
            r_c_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_c_sqx  <= SQ_W'(r_b_side.mag_x) * SQ_W'(r_b_side.mag_x);
        r_c_sqy  <= SQ_W'(r_b_side.mag_y) * SQ_W'(r_b_side.mag_y);
        r_c_side <= r_b_side;
    end

    // ------------------------------------------- stage D: squared distance
    logic            r_d_vld;
    logic [SQ_W-1:0] r_d_sq;
    t_sqrt_side      r_d_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
        end else begin
            r_d_vld <= r_c_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d_sq   <= r_c_sqx + r_c_sqy;
        r_d_side <= r_c_side;
    end

    // ---------------------------------------------------------- square root
    logic              sq_vld;
    logic [ROOT_W-1:0] sq_root;
    t_sqrt_side        sq_side;

    cor_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r_d_vld),
        .i_radicand (r_d_sq),
        .i_side     (r_d_side),
        .o_valid    (sq_vld),
        .o_root     (sq_root),
        .o_side     (sq_side)
    );

    // ------------------------------------------- stage E: overlap decision
    logic [SW-1:0]     rad_sum;
    logic              hit;
    t_div_side         n_e_side;
    logic [ELAS_W-1:0] elas_eff;
    logic              r_e_vld;
    t_div_side         r_e_side;
    logic [SW-1:0]     r_e_depth;
    logic [SW-1:0]     r_e_magx;
    logic [SW-1:0]     r_e_magy;
    logic [SW-1:0]     r_e_len;
    logic [ELAS_W-1:0] r_e_elas;

    always_comb begin
        rad_sum        = SW'(sq_side.rsum) << FRACTION_BITS;
        hit            = (sq_root != '0) && (sq_root < ROOT_W'(rad_sum));
        elas_eff       = (r_elas > ELAS_MAX) ? ELAS_MAX : r_elas;
        n_e_side.x1    = sq_side.x1;
        n_e_side.y1    = sq_side.y1;
        n_e_side.x2    = sq_side.x2;
        n_e_side.y2    = sq_side.y2;
        n_e_side.neg_x = sq_side.neg_x;
        n_e_side.neg_y = sq_side.neg_y;
        n_e_side.hit   = hit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
        end else begin
            r_e_vld <= sq_vld;
        end
    end

    // Magnitudes never exceed the length on a hit, so truncation is safe
    always_ff @(posedge i_clk) begin
        r_e_side  <= n_e_side;
        r_e_depth <= rad_sum - sq_root[SW-1:0];
        r_e_magx  <= sq_side.mag_x[SW-1:0];
        r_e_magy  <= sq_side.mag_y[SW-1:0];
        r_e_len   <= sq_root[SW-1:0];
        r_e_elas  <= elas_eff;
    end

    // --------------------------------------- stage F: elasticity times depth
    logic              r_f_vld;
    t_div_side         r_f_side;
    logic [PROD_W-1:0] r_f_ed;
    logic [SW-1:0]     r_f_magx;
    logic [SW-1:0]     r_f_magy;
    logic [SW-1:0]     r_f_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
        end else begin
            r_f_vld <= r_e_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_f_side <= r_e_side;
        r_f_ed   <= PROD_W'(r_e_elas) * PROD_W'(r_e_depth);
        r_f_magx <= r_e_magx;
        r_f_magy <= r_e_magy;
        r_f_len  <= r_e_len;
    end

    // ------------------------------------------ stage G: times each axis
    logic             r_g_vld;
    t_div_side        r_g_side;
    logic [MUL_W-1:0] r_g_px;
    logic [MUL_W-1:0] r_g_py;
    logic [DEN_W-1:0] r_g_den;
    logic [NUM_W-1:0] r_g_half;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_vld <= 1'b0;
        end else begin
            r_g_vld <= r_f_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_g_side <= r_f_side;
        r_g_px   <= MUL_W'(r_f_ed) * MUL_W'(r_f_magx);
        r_g_py   <= MUL_W'(r_f_ed) * MUL_W'(r_f_magy);
        r_g_den  <= DEN_W'(r_f_len) << ELAS_FRAC;
        r_g_half <= NUM_W'(r_f_len) << (ELAS_FRAC - 1);
    end

    // ------------------------------------------- stage H: add rounding half
    logic             r_h_vld;
    t_div_side        r_h_side;
    logic [NUM_W-1:0] r_h_numx;
    logic [NUM_W-1:0] r_h_numy;
    logic [DEN_W-1:0] r_h_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_vld <= 1'b0;
        end else begin
            r_h_vld <= r_g_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_h_side <= r_g_side;
        r_h_numx <= NUM_W'(r_g_px) + r_g_half;
        r_h_numy <= NUM_W'(r_g_py) + r_g_half;
        r_h_den  <= r_g_den;
    end

    // -------------------------------------------------------------- divider
    logic             dv_vld;
    logic [QUO_W-1:0] dv_qx;
    logic [QUO_W-1:0] dv_qy;
    t_div_side        dv_side;

    cor_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W),
        .QUO_W (QUO_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_h_vld),
        .i_num_x (r_h_numx),
        .i_num_y (r_h_numy),
        .i_den   (r_h_den),
        .i_side  (r_h_side),
        .o_valid (dv_vld),
        .o_quo_x (dv_qx),
        .o_quo_y (dv_qy),
        .o_side  (dv_side)
    );

    // ------------------------------------- stage I: apply offsets, saturate
    logic [EXT_W-1:0] ofs_x;
    logic [EXT_W-1:0] ofs_y;
    logic [EXT_W-1:0] ext_x1;
    logic [EXT_W-1:0] ext_y1;
    logic [EXT_W-1:0] ext_x2;
    logic [EXT_W-1:0] ext_y2;
    t_pair_out        n_out;
    logic             r_o_vld;
    t_pair_out        r_o_res;

    always_comb begin
        ofs_x  = dv_side.neg_x ? -EXT_W'(dv_qx) : EXT_W'(dv_qx);
        ofs_y  = dv_side.neg_y ? -EXT_W'(dv_qy) : EXT_W'(dv_qy);
        ext_x1 = {{(EXT_W-COORD_W){dv_side.x1[COORD_W-1]}}, dv_side.x1};
        ext_y1 = {{(EXT_W-COORD_W){dv_side.y1[COORD_W-1]}}, dv_side.y1};
        ext_x2 = {{(EXT_W-COORD_W){dv_side.x2[COORD_W-1]}}, dv_side.x2};
        ext_y2 = {{(EXT_W-COORD_W){dv_side.y2[COORD_W-1]}}, dv_side.y2};
        if (dv_side.hit) begin
            n_out.first_x_out  = sat_coord(ext_x1 + ofs_x);
            n_out.first_y_out  = sat_coord(ext_y1 + ofs_y);
            n_out.second_x_out = sat_coord(ext_x2 - ofs_x);
            n_out.second_y_out = sat_coord(ext_y2 - ofs_y);
        end else begin
            n_out.first_x_out  = dv_side.x1;
            n_out.first_y_out  = dv_side.y1;
            n_out.second_x_out = dv_side.x2;
            n_out.second_y_out = dv_side.y2;
        end
        n_out.overlapped = dv_side.hit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else begin
            r_o_vld <= dv_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_o_res <= n_out;
    end

    assign o_valid  = r_o_vld;
    assign o_result = r_o_res;

endmodule

// File: sim/circle_overlap_resolver_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// circle_overlap_resolver_tb
// Self-checking bench: directed pairs from a table, then random pairs biased
// towards overlap, each predicted in the bench and compared per field.
// ============================================================================
module circle_overlap_resolver_tb;
    import cor_pkg::*;

    localparam int FRAC    = 8;
    localparam int LATENCY = 43 + FRAC;
    localparam int N_RAND  = 450;

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            i_cfg_we = 1'b0;
    logic [ELAS_W-1:0] i_cfg_wdata = '0;
    logic            start = 1'b0;
    t_pair_in        i_pair = '0;
    logic            busy;
    logic            o_valid;
    t_pair_out       o_result;

    logic [ELAS_W-1:0] elas_shadow;
    t_pair_out       pending_q[$];
    int              n_fail = 0;
    int              n_hits = 0;
    int              n_results = 0;

    circle_overlap_resolver #(.FRACTION_BITS(FRAC)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata), .start(start), .i_pair(i_pair),
        .busy(busy), .o_valid(o_valid), .o_result(o_result)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    initial begin
        #20_000_000;
        $display("circle_overlap_resolver test failed");
        $finish;
    end

    function automatic logic [63:0] isqrt(logic [63:0] n);
        logic [63:0] root;
        logic [63:0] b;
        root = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= root + b) begin
                n = n - (root + b);
                root = (root >> 1) + b;
            end else begin
                root = root >> 1;
            end
            b = b >> 2;
        end
        return root;
    endfunction

    function automatic logic signed [COORD_W-1:0] clamp24(longint v);
        if (v > 64'sd8388607) v = 64'sd8388607;
        if (v < -64'sd8388608) v = -64'sd8388608;
        return v[COORD_W-1:0];
    endfunction

    function automatic longint push_axis(longint d, longint e, longint depth,
                                         longint len);
        longint mag;
        longint den;
        longint q;
        mag = (d < 0) ? -d : d;
        den = len * 256;
        q = (e * depth * mag + den / 2) / den;
        return (d < 0) ? -q : q;
    endfunction

    // Predict the corrected pair for the current elasticity
    function automatic t_pair_out resolve_pair(t_pair_in p, logic [ELAS_W-1:0] el);
        t_pair_out r;
        longint x1, y1, x2, y2, dx, dy, len, rsum, e, ox, oy;
        x1 = p.first_x_in;  y1 = p.first_y_in;
        x2 = p.second_x_in; y2 = p.second_y_in;
        dx = x1 - x2; dy = y1 - y2;
        len = isqrt(dx * dx + dy * dy);
        rsum = (longint'(p.first_radius) + longint'(p.second_radius)) << FRAC;
        e = (el > ELAS_MAX) ? 256 : el;
        r.overlapped = 1'b0;
        if (len > 0 && len < rsum) begin
            ox = push_axis(dx, e, rsum - len, len);
            oy = push_axis(dy, e, rsum - len, len);
            x1 += ox; y1 += oy; x2 -= ox; y2 -= oy;
            r.overlapped = 1'b1;
        end
        r.first_x_out = clamp24(x1);
        r.first_y_out = clamp24(y1);
        r.second_x_out = clamp24(x2);
        r.second_y_out = clamp24(y2);
        return r;
    endfunction

    // Compare each strobed result against the oldest prediction
    always @(posedge i_clk) begin
        t_pair_out exp_r;
        if (i_rst_n && o_valid) begin
            n_results++;
            if (pending_q.size() == 0) begin
                $error("result with nothing pending");
                n_fail++;
            end else begin
                exp_r = pending_q.pop_front();
                if (exp_r.overlapped) n_hits++;
                if (o_result.first_x_out !== exp_r.first_x_out) begin
                    $error("first_x_out exp %0d got %0d", exp_r.first_x_out,
                           o_result.first_x_out); n_fail++;
                end
                if (o_result.first_y_out !== exp_r.first_y_out) begin
                    $error("first_y_out exp %0d got %0d", exp_r.first_y_out,
                           o_result.first_y_out); n_fail++;
                end
                if (o_result.second_x_out !== exp_r.second_x_out) begin
                    $error("second_x_out exp %0d got %0d", exp_r.second_x_out,
                           o_result.second_x_out); n_fail++;
                end
                if (o_result.second_y_out !== exp_r.second_y_out) begin
                    $error("second_y_out exp %0d got %0d", exp_r.second_y_out,
                           o_result.second_y_out); n_fail++;
                end
                if (o_result.overlapped !== exp_r.overlapped) begin
                    $error("overlapped exp %0b got %0b", exp_r.overlapped,
                           o_result.overlapped); n_fail++;
                end
            end
        end
    end

    // Issue one pair; hold start across back-to-back transfers, drop it for a gap
    task automatic send_pair(t_pair_in p);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
        if ($urandom_range(0, 4) == 0) gap = 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_pair <= p;
        do @(posedge i_clk); while (busy);
        pending_q.insert(pending_q.size(), resolve_pair(p, elas_shadow));
    endtask

    task automatic drain_and_write(logic [ELAS_W-1:0] v);
        int guard;
        guard = 0;
        start <= 1'b0;
        while (pending_q.size() != 0 && guard < 100000) begin
            @(posedge i_clk); guard++;
        end
        repeat (4) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        elas_shadow = v;
    endtask

    function automatic t_pair_in mk(int x1, int y1, int r1, int x2, int y2, int r2);
        t_pair_in p;
        p.first_x_in = COORD_W'(x1); p.first_y_in = COORD_W'(y1);
        p.first_radius = RAD_W'(r1);
        p.second_x_in = COORD_W'(x2); p.second_y_in = COORD_W'(y2);
        p.second_radius = RAD_W'(r2);
        return p;
    endfunction

    // Random pair: mostly near neighbours so overlaps are common
    function automatic t_pair_in rand_pair();
        t_pair_in p;
        int k;
        k = $urandom_range(0, 9);
        p = t_pair_in'({$urandom, $urandom, $urandom, $urandom});
        if (k < 7) begin
            p.second_x_in = COORD_W'(p.first_x_in + $signed($urandom_range(0, 40000))
                                     - 20000);
            p.second_y_in = COORD_W'(p.first_y_in + $signed($urandom_range(0, 40000))
                                     - 20000);
        end else if (k == 7) begin
            p.first_x_in = COORD_W'(24'h7FFF00 | $urandom_range(0, 255));
            p.second_x_in = COORD_W'(p.first_x_in - $urandom_range(0, 5000));
            p.second_y_in = p.first_y_in;
        end
        return p;
    endfunction

    typedef struct {
        t_pair_in  pair;
        logic      typed;
        t_pair_out res;
    } t_row;

    initial begin
        t_row rows[$];
        t_row row;
        t_pair_in p;
        logic [ELAS_W-1:0] settings[5] = '{9'd0, 9'd256, 9'd511, 9'd1, 9'd200};
        int guard;
        elas_shadow = ELAS_RESET;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table: typed rows are passthrough cases
        row.typed = 1;
        row.pair = mk(100, -100, 5, 100, -100, 5);         // coincident centres
        row.res = '{24'sd100, -24'sd100, 24'sd100, -24'sd100, 1'b0};
        rows.insert(rows.size(), row);
        row.pair = mk(0, 0, 0, 1, 0, 0);                   // zero radii
        row.res = '{24'sd0, 24'sd0, 24'sd1, 24'sd0, 1'b0}; rows.insert(rows.size(), row);
        row.pair = mk(-8388608, -8388608, 255, 8388607, 8388607, 255); // far apart
        row.res = '{-24'sd8388608, -24'sd8388608, 24'sd8388607, 24'sd8388607, 1'b0};
        rows.insert(rows.size(), row);
        row.pair = mk(0, 0, 1, 512, 0, 1);                 // just touching
        row.res = '{24'sd0, 24'sd0, 24'sd512, 24'sd0, 1'b0}; rows.insert(rows.size(), row);
        row.typed = 0;
        rows.insert(rows.size(), '{mk(0, 0, 10, 256, 0, 10), 0, '0});
        rows.insert(rows.size(), '{mk(0, 0, 255, 0, -1, 255), 0, '0});
        rows.insert(rows.size(), '{mk(8388607, 8388607, 255, 8388600, 8388600, 255), 0, '0});
        rows.insert(rows.size(),
                    '{mk(-8388608, -8388608, 255, -8388600, -8388601, 255), 0, '0});
        rows.insert(rows.size(), '{mk(1000, 2000, 3, 900, 2100, 4), 0, '0});
        rows.insert(rows.size(), '{mk(-5, 7, 255, 3, -2, 0), 0, '0});
        rows.insert(rows.size(), '{mk(0, 0, 0, 1, 1, 255), 0, '0});

        foreach (rows[i]) begin
            send_pair(rows[i].pair);
            if (rows[i].typed) begin
                pending_q.pop_back();
                pending_q.insert(pending_q.size(), rows[i].res);
            end
        end

        // Random pairs across several elasticity settings
        for (int s = 0; s < 6; s++) begin
            if (s > 0) drain_and_write(settings[s-1]);
            for (int n = 0; n < N_RAND / 6; n++) send_pair(rand_pair());
            if (s == 2) foreach (rows[i]) send_pair(rows[i].pair);
        end

        start <= 1'b0;
        guard = 0;
        while (pending_q.size() != 0 && guard < 200000) begin
            @(posedge i_clk); guard++;
        end
        repeat (LATENCY + 10) @(posedge i_clk);
        if (pending_q.size() != 0) begin
            $error("%0d results never arrived", pending_q.size());
            n_fail++;
        end
        $display("Checked %0d results, %0d pushed apart, over 6 elasticity settings",
                 n_results, n_hits);
        if (n_fail == 0) $display("circle_overlap_resolver test passed");
        else $display("circle_overlap_resolver test failed");
        $finish;
    end
endmodule
